// ----- src/line_rasterizer_defines.svh -----
// Assertion macros for the checker file lr_checker.sv.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Check a condition at every clock edge, reset included.
`define LR_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

// Same-cycle implication, idle in reset.
`define LR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle in reset.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lr_pkg.sv -----
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COL_BITS   = 9;
    localparam int ROW_BITS   = 8;
    localparam int CRD_BITS   = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int ERR_BITS   = CRD_BITS + 2;
    localparam int ADDR_BITS  = 32;
    localparam int RED_BITS   = 5;
    localparam int GREEN_BITS = 6;
    localparam int BLUE_BITS  = 5;
    localparam int COLOR_BITS = RED_BITS + GREEN_BITS + BLUE_BITS;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } lr_cmd_t;

    // One request as held in the input register
    typedef struct packed {
        lr_cmd_t               cmd;
        logic [COL_BITS-1:0]   x_start;
        logic [ROW_BITS-1:0]   y_start;
        logic [COL_BITS-1:0]   x_end;
        logic [ROW_BITS-1:0]   y_end;
        logic [RED_BITS-1:0]   red;
        logic [GREEN_BITS-1:0] green;
        logic [BLUE_BITS-1:0]  blue;
    } lr_req_t;

    // Walker state of one line
    typedef struct packed {
        logic                       steep;
        logic [CRD_BITS-1:0]        major_pos;
        logic [CRD_BITS-1:0]        minor_pos;
        logic [CRD_BITS-1:0]        major_end;
        logic [CRD_BITS-1:0]        delta_major;
        logic [CRD_BITS-1:0]        delta_minor;
        logic signed [ERR_BITS-1:0] error_term;
        logic                       minor_down;
        logic [COLOR_BITS-1:0]      line_color;
    } lr_line_t;

    // One pixel write
    typedef struct packed {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_value;
        logic                  last;
    } lr_pix_t;

endpackage

// ----- src/lr_in_if.sv -----
`timescale 1ns / 1ps

interface lr_in_if;
    import lr_pkg::*;

    logic                  valid;
    logic                  ready;
    lr_cmd_t               cmd;
    logic [COL_BITS-1:0]   x_start;
    logic [ROW_BITS-1:0]   y_start;
    logic [COL_BITS-1:0]   x_end;
    logic [ROW_BITS-1:0]   y_end;
    logic [RED_BITS-1:0]   red;
    logic [GREEN_BITS-1:0] green;
    logic [BLUE_BITS-1:0]  blue;

    modport source (
        output valid, cmd, x_start, y_start, x_end, y_end, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, cmd, x_start, y_start, x_end, y_end, red, green, blue,
        output ready
    );

endinterface

// ----- src/lr_out_if.sv -----
`timescale 1ns / 1ps

interface lr_out_if;
    import lr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_value;
    logic                  last;

    modport source (
        output valid, pixel_address, pixel_value, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_address, pixel_value, last,
        output ready
    );

endinterface

// ----- src/line_rasterizer.sv -----
`timescale 1ns / 1ps
// Bresenham line rasterizer for a 512 x 256 RGB565 frame buffer.
// Requests arrive on in_ch (valid/ready). A load request (cmd LOAD) takes two
// endpoints and a colour and primes the walker; any unfinished line is
// dropped. A step request (cmd STEP) yields one pixel write on out_ch: the
// byte address frame_base + row*1024 + column*2, the packed colour, and last
// on the final pixel. A step with no line loaded, and every load, yield
// nothing. Write frame_base via cfg_we/cfg_data only while idle (unenforced).
// Timing: the edge that takes a step request loads the request register, and
// the pixel register loads the pixel once the walker may advance, so the
// pixel shows on out_ch after both registers; an out_ch stall can delay it.
// Throughput: one request per cycle while out_ch is not held off; the walker
// state feeds back to itself, so consecutive steps do not wait on each other.
// Stall: while out_ch is held off, the pixel register holds its write and the
// request register takes one more request if empty, then in_ch.ready drops.
// Reset (rst_n low, asynchronous) empties both registers, clears the walker
// to no line loaded and sets frame_base to zero.

module line_rasterizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lr_pkg::ADDR_BITS-1:0] cfg_data,
    lr_in_if.sink                        in_ch,
    lr_out_if.source                     out_ch
);
    import lr_pkg::*;

    logic                 req_valid_reg;
    lr_req_t              req_reg;
    logic                 out_valid_reg;
    lr_pix_t              pix_reg;
    logic [ADDR_BITS-1:0] frame_base_reg;

    logic     out_free;
    logic     advance;
    logic     emit;
    lr_pix_t  pix;
    lr_line_t setup;

    // The walker may advance whenever the pixel register is empty or is
    // being emptied this cycle; a load never needs the pixel register but
    // waits with the rest to keep requests in order.
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = req_valid_reg && out_free;
    assign in_ch.ready = !req_valid_reg || out_free;

    // Frame base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            frame_base_reg <= cfg_data;
        end
    end

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            req_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            req_reg.cmd     <= in_ch.cmd;
            req_reg.x_start <= in_ch.x_start;
            req_reg.y_start <= in_ch.y_start;
            req_reg.x_end   <= in_ch.x_end;
            req_reg.y_end   <= in_ch.y_end;
            req_reg.red     <= in_ch.red;
            req_reg.green   <= in_ch.green;
            req_reg.blue    <= in_ch.blue;
        end
    end

    // Orientation, ordering and error priming for a load
    lr_setup u_setup (
        .req  (req_reg),
        .line (setup)
    );

    // Walker state and pixel address
    lr_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .req        (req_reg),
        .setup      (setup),
        .frame_base (frame_base_reg),
        .emit       (emit),
        .pix        (pix)
    );

    // Pixel register: hold while stalled, refill when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_reg <= pix;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_address = pix_reg.pixel_address;
    assign out_ch.pixel_value   = pix_reg.pixel_value;
    assign out_ch.last          = pix_reg.last;

endmodule

// ----- src/lr_setup.sv -----
`timescale 1ns / 1ps

module lr_setup (
    input  lr_pkg::lr_req_t  req,
    output lr_pkg::lr_line_t line
);
    import lr_pkg::*;

    logic [COL_BITS-1:0] span_x;
    logic [ROW_BITS-1:0] span_y;
    logic                steep;
    logic [CRD_BITS-1:0] a0;
    logic [CRD_BITS-1:0] b0;
    logic [CRD_BITS-1:0] a1;
    logic [CRD_BITS-1:0] b1;
    logic [CRD_BITS-1:0] lo_a;
    logic [CRD_BITS-1:0] lo_b;
    logic [CRD_BITS-1:0] hi_a;
    logic [CRD_BITS-1:0] hi_b;
    logic [CRD_BITS-1:0] d_major;

    always_comb
    begin
        span_x = (req.x_end > req.x_start) ? (req.x_end - req.x_start)
                                           : (req.x_start - req.x_end);
        span_y = (req.y_end > req.y_start) ? (req.y_end - req.y_start)
                                           : (req.y_start - req.y_end);
        steep  = CRD_BITS'(span_x) < CRD_BITS'(span_y);

        // pick the major axis
        if (steep)
        begin
            a0 = CRD_BITS'(req.y_start);
            b0 = CRD_BITS'(req.x_start);
            a1 = CRD_BITS'(req.y_end);
            b1 = CRD_BITS'(req.x_end);
        end
        else
        begin
            a0 = CRD_BITS'(req.x_start);
            b0 = CRD_BITS'(req.y_start);
            a1 = CRD_BITS'(req.x_end);
            b1 = CRD_BITS'(req.y_end);
        end

        // order so the major coordinate rises
        if (a0 > a1)
        begin
            lo_a = a1;
            lo_b = b1;
            hi_a = a0;
            hi_b = b0;
        end
        else
        begin
            lo_a = a0;
            lo_b = b0;
            hi_a = a1;
            hi_b = b1;
        end

        d_major = hi_a - lo_a;

        line.steep       = steep;
        line.major_pos   = lo_a;
        line.minor_pos   = lo_b;
        line.major_end   = hi_a;
        line.delta_major = d_major;
        line.delta_minor = (hi_b > lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);
        line.error_term  = -$signed(ERR_BITS'(d_major >> 1));
        line.minor_down  = !(lo_b < hi_b);
        line.line_color  = {req.red, req.green, req.blue};
    end

endmodule

// ----- src/lr_step.sv -----
`timescale 1ns / 1ps

module lr_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  lr_pkg::lr_req_t              req,
    input  lr_pkg::lr_line_t             setup,
    input  logic [lr_pkg::ADDR_BITS-1:0] frame_base,
    output logic                         emit,
    output lr_pkg::lr_pix_t              pix
);
    import lr_pkg::*;

    logic                       active_reg;
    logic                       active_next;
    lr_line_t                   line_reg;
    lr_line_t                   line_next;
    logic [COL_BITS-1:0]        col;
    logic [ROW_BITS-1:0]        row;
    logic                       is_last;
    logic signed [ERR_BITS-1:0] err_sum;

    always_comb
    begin
        emit = advance && (req.cmd == CMD_STEP) && active_reg;

        col = line_reg.steep ? line_reg.minor_pos[COL_BITS-1:0]
                             : line_reg.major_pos[COL_BITS-1:0];
        row = line_reg.steep ? line_reg.major_pos[ROW_BITS-1:0]
                             : line_reg.minor_pos[ROW_BITS-1:0];
        is_last = (line_reg.major_pos == line_reg.major_end);

        pix.pixel_address = frame_base + ADDR_BITS'({row, col, 1'b0});
        pix.pixel_value   = line_reg.line_color;
        pix.last          = is_last;

        err_sum = line_reg.error_term + $signed(ERR_BITS'(line_reg.delta_minor));

        active_next = active_reg;
        line_next   = line_reg;
        if (advance && (req.cmd == CMD_LOAD))
        begin
            active_next = 1'b1;
            line_next   = setup;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                line_next.error_term = err_sum;
                if (!err_sum[ERR_BITS-1])
                begin
                    line_next.minor_pos = line_reg.minor_down
                                        ? (line_reg.minor_pos - 1'b1)
                                        : (line_reg.minor_pos + 1'b1);
                    line_next.error_term =
                        err_sum - $signed(ERR_BITS'(line_reg.delta_major));
                end
                line_next.major_pos = line_reg.major_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            line_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            line_reg   <= line_next;
        end
    end

endmodule

// ----- src/lr_checker.sv -----
`timescale 1ns / 1ps
`include "line_rasterizer_defines.svh"

module lr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [lr_pkg::ADDR_BITS-1:0] out_addr,
    input logic                         out_last
);
    import lr_pkg::*;

    // Reset empties the pixel register at once.
    `LR_ASSERT_ALWAYS(a_reset_empty, clk, rst_n || !out_valid, "pixel shown in reset")

    // With the pixel register empty, a request is always taken.
    `LR_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "blocked while empty")

    // A stalled pixel stays offered and unchanged.
    `LR_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid, "pixel dropped")
    `LR_ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && !out_ready,
        $stable(out_addr) && $stable(out_last), "pixel changed while stalled")

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_addr  (out_ch.pixel_address),
    .out_last  (out_ch.last)
);
